// File: rtl/divide_128_by_64_defines.svh
`ifndef DIVIDE_128_BY_64_DEFINES_SVH
`define DIVIDE_128_BY_64_DEFINES_SVH

// same-cycle implication, checked at every edge out of reset
`define DIV128_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("divider check failed");

// next-cycle implication
`define DIV128_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("divider check failed");

`endif

// File: rtl/div128_pkg.sv
package div128_pkg;

   localparam int FIELD_BITS        = 64;
   localparam int WORD_BITS_DEFAULT = 64;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic divisor_zero;
   } status_type;

endpackage

// File: rtl/divide_128_by_64.sv
// channel   ports                                                     handshake
// request   req_divisor, req_dividend_low/high                        start && !busy
// response  rsp_quotient_low/high, rsp_remainder, rsp_divide_by_zero  rsp_valid, one cycle
//
// a word is divided by the shared subtractor between start and the response strobe,
// one quotient bit per cycle over the whole dividend
// a zero divisor skips the bit loop: response in the cycle after start
// busy stays high until the cycle after the strobe; start is ignored while busy
// reset clears the controller only; the response cannot be held off
module divide_128_by_64 #(
   parameter int WORD_BITS = div128_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_divisor,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_low,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_high,
   output logic                              rsp_valid,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_low,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_high,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_remainder,
   output logic                              rsp_divide_by_zero
);
   import div128_pkg::*;

   cmd_type    cmd;
   status_type status;

   div128_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   div128_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_divisor        (req_divisor),
      .req_dividend_low   (req_dividend_low),
      .req_dividend_high  (req_dividend_high),
      .rsp_quotient_low   (rsp_quotient_low),
      .rsp_quotient_high  (rsp_quotient_high),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// File: rtl/div128_ctrl.sv
module div128_ctrl #(
   parameter int WORD_BITS = div128_pkg::WORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  div128_pkg::status_type status,
   output div128_pkg::cmd_type    cmd
);
   import div128_pkg::*;

   localparam int STEPS    = 2 * WORD_BITS;
   localparam int CNT_BITS = $clog2(STEPS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                accept;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign accept    = start && !busy;

   always_comb begin
      cmd.load = accept;
      cmd.step = (state_ff == ST_RUN);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = CNT_BITS'(STEPS - 1);
               state_in = status.divisor_zero ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/div128_dp.sv
module div128_dp #(
   parameter int WORD_BITS = div128_pkg::WORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  div128_pkg::cmd_type               cmd,
   output div128_pkg::status_type            status,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_divisor,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_low,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_high,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_low,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_high,
   output logic [div128_pkg::FIELD_BITS-1:0] rsp_remainder,
   output logic                              rsp_divide_by_zero
);
   import div128_pkg::*;

   logic [WORD_BITS-1:0]   divisor_ff;
   logic [WORD_BITS-1:0]   rem_ff;
   logic [2*WORD_BITS-1:0] quo_ff;
   logic                   dbz_ff;
   logic [WORD_BITS:0]     shifted;
   logic [WORD_BITS+1:0]   trial;
   logic                   fits;

   assign status.divisor_zero = (req_divisor[WORD_BITS-1:0] == '0);

   // partial remainder shifted left with the next dividend bit, then trial subtract
   assign shifted = {rem_ff, quo_ff[2*WORD_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = !trial[WORD_BITS+1];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         divisor_ff <= req_divisor[WORD_BITS-1:0];
         rem_ff     <= '0;
         quo_ff     <= {req_dividend_high[WORD_BITS-1:0], req_dividend_low[WORD_BITS-1:0]};
         dbz_ff     <= status.divisor_zero;
      end else if (cmd.step) begin
         rem_ff <= fits ? trial[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
         quo_ff <= {quo_ff[2*WORD_BITS-2:0], fits};
      end
   end

   assign rsp_quotient_low   = dbz_ff ? '0 : FIELD_BITS'(quo_ff[WORD_BITS-1:0]);
   assign rsp_quotient_high  = dbz_ff ? '0 : FIELD_BITS'(quo_ff[2*WORD_BITS-1:WORD_BITS]);
   assign rsp_remainder      = dbz_ff ? '0 : FIELD_BITS'(rem_ff);
   assign rsp_divide_by_zero = dbz_ff;

endmodule

// File: rtl/div128_checker.sv
`include "divide_128_by_64_defines.svh"

module div128_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_low,
   input logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_high,
   input logic [div128_pkg::FIELD_BITS-1:0] rsp_remainder,
   input logic                              rsp_divide_by_zero
);

   logic results_zero;

   assign results_zero = (rsp_quotient_low == '0) && (rsp_quotient_high == '0)
                         && (rsp_remainder == '0);

   `DIV128_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `DIV128_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `DIV128_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy)
   `DIV128_ASSERT_NOW(a_zero_results, clock, reset, rsp_valid && rsp_divide_by_zero, results_zero)

endmodule

bind divide_128_by_64 div128_checker u_div128_checker (.*);

// File: tb/quotient_checker.sv
module quotient_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_divisor,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_low,
   input  logic [div128_pkg::FIELD_BITS-1:0] req_dividend_high,
   input  logic                              rsp_valid,
   input  logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_low,
   input  logic [div128_pkg::FIELD_BITS-1:0] rsp_quotient_high,
   input  logic [div128_pkg::FIELD_BITS-1:0] rsp_remainder,
   input  logic                              rsp_divide_by_zero,
   output int                                mismatches,
   output int                                outstanding
);
   import div128_pkg::*;

   localparam int WORD_BITS = WORD_BITS_DEFAULT;
   localparam logic [FIELD_BITS-1:0] WORD_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);

   typedef struct {
      logic [FIELD_BITS-1:0] low;
      logic [FIELD_BITS-1:0] high;
      logic [FIELD_BITS-1:0] rem;
      logic                  by_zero;
   } quotient_word;

   quotient_word expected_quotients[$];
   quotient_word want;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // restoring divider with a partial remainder one bit wider than the word
   function automatic quotient_word divide_exact(input logic [FIELD_BITS-1:0] d_in,
                                                 input logic [FIELD_BITS-1:0] lo_in,
                                                 input logic [FIELD_BITS-1:0] hi_in);
      quotient_word          q;
      logic [FIELD_BITS:0]   part;
      logic [FIELD_BITS-1:0] d;
      logic [FIELD_BITS-1:0] lo;
      logic [FIELD_BITS-1:0] hi;
      int                    i;
      d         = d_in & WORD_MASK;
      lo        = lo_in & WORD_MASK;
      hi        = hi_in & WORD_MASK;
      q.low     = '0;
      q.high    = '0;
      q.rem     = '0;
      q.by_zero = 1'b0;
      if (d == '0) begin
         q.by_zero = 1'b1;
         return q;
      end
      q.high = hi / d;
      part   = {1'b0, hi % d};
      for (i = WORD_BITS - 1; i >= 0; i--) begin
         part  = (part << 1) | lo[i];
         q.low = q.low << 1;
         if (part >= {1'b0, d}) begin
            part     = part - {1'b0, d};
            q.low[0] = 1'b1;
         end
      end
      q.low  = q.low & WORD_MASK;
      q.high = q.high & WORD_MASK;
      q.rem  = part[FIELD_BITS-1:0] & WORD_MASK;
      return q;
   endfunction

   task automatic report_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
                                  input logic [FIELD_BITS-1:0] exp_value);
      $display("checker: %s got %h wanted %h", what, got, exp_value);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_quotients.push_back(divide_exact(req_divisor, req_dividend_low,
                                                      req_dividend_high));
         end
         if (rsp_valid) begin
            if (expected_quotients.size() == 0) begin
               report_mismatch("word with nothing outstanding, quotient_low", rsp_quotient_low,
                               '0);
            end else begin
               want = expected_quotients.pop_front();
               if (rsp_quotient_low !== want.low)
                  report_mismatch("quotient_low", rsp_quotient_low, want.low);
               if (rsp_quotient_high !== want.high)
                  report_mismatch("quotient_high", rsp_quotient_high, want.high);
               if (rsp_remainder !== want.rem)
                  report_mismatch("remainder", rsp_remainder, want.rem);
               if (rsp_divide_by_zero !== want.by_zero)
                  report_mismatch("divide_by_zero", FIELD_BITS'(rsp_divide_by_zero),
                                  FIELD_BITS'(want.by_zero));
            end
         end
      end
      outstanding <= expected_quotients.size();
   end

endmodule

// File: tb/tb.sv
module tb;
   import div128_pkg::*;

   localparam int ITEMS      = 1500;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE     = 140;

   localparam logic [FIELD_BITS-1:0] ALL_ONES = {FIELD_BITS{1'b1}};
   localparam logic [FIELD_BITS-1:0] TOP_BIT  = {1'b1, {(FIELD_BITS-1){1'b0}}};

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  start             = 1'b0;
   logic [FIELD_BITS-1:0] req_divisor       = '0;
   logic [FIELD_BITS-1:0] req_dividend_low  = '0;
   logic [FIELD_BITS-1:0] req_dividend_high = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [FIELD_BITS-1:0] rsp_quotient_low;
   logic [FIELD_BITS-1:0] rsp_quotient_high;
   logic [FIELD_BITS-1:0] rsp_remainder;
   logic                  rsp_divide_by_zero;
   int                    mismatches;
   int                    outstanding;
   int                    idle_cycles       = 0;

   always #2 clock = ~clock;

   divide_128_by_64 dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_divisor        (req_divisor),
      .req_dividend_low   (req_dividend_low),
      .req_dividend_high  (req_dividend_high),
      .rsp_valid          (rsp_valid),
      .rsp_quotient_low   (rsp_quotient_low),
      .rsp_quotient_high  (rsp_quotient_high),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   quotient_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_divisor        (req_divisor),
      .req_dividend_low   (req_dividend_low),
      .req_dividend_high  (req_dividend_high),
      .rsp_valid          (rsp_valid),
      .rsp_quotient_low   (rsp_quotient_low),
      .rsp_quotient_high  (rsp_quotient_high),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [FIELD_BITS-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // gap counts idle cycles once the divider is free
   task automatic send_word(input logic [FIELD_BITS-1:0] d, input logic [FIELD_BITS-1:0] lo,
                            input logic [FIELD_BITS-1:0] hi, input int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat (gap - 1) @(posedge clock);
      end
      start             <= 1'b1;
      req_divisor       <= d;
      req_dividend_low  <= lo;
      req_dividend_high <= hi;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [FIELD_BITS-1:0] d;
      logic [FIELD_BITS-1:0] lo;
      logic [FIELD_BITS-1:0] hi;
      int                    n;
      int                    max_gap;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero divisor, plain cases, top-bit divisors where the carry matters
      send_word('0, '0, '0, 3);
      send_word('0, ALL_ONES, ALL_ONES, 3);
      send_word('0, 64'h1234_5678_9abc_def0, 64'h1, 3);
      send_word(64'h1, '0, '0, 3);
      send_word(64'h1, ALL_ONES, ALL_ONES, 3);
      send_word(64'h2, ALL_ONES, ALL_ONES, 3);
      send_word(ALL_ONES, ALL_ONES, ALL_ONES, 3);
      send_word(ALL_ONES, ALL_ONES, ALL_ONES - 1, 3);
      send_word(ALL_ONES, '0, '0, 3);
      send_word(TOP_BIT, ALL_ONES, TOP_BIT - 1, 3);
      send_word(TOP_BIT, '0, TOP_BIT, 3);
      send_word(TOP_BIT + 1, ALL_ONES, TOP_BIT, 3);
      send_word(TOP_BIT + 1, '0, TOP_BIT, 3);
      send_word(ALL_ONES - 1, ALL_ONES, ALL_ONES - 2, 3);
      send_word(64'h3, 64'h5555_5555_5555_5555, 64'h2, 3);
      send_word(64'hffff_ffff, ALL_ONES, 64'hffff_fffe, 3);
      send_word(64'h1_0000_0000, 64'hdead_beef_0000_0001, ALL_ONES, 3);
      send_word(64'h7, 64'h6, '0, 3);
      send_word(ALL_ONES, ALL_ONES - 1, '0, 3);
      send_word(64'h8000_0000_0000_0001, 64'h1, ALL_ONES, 3);
      drain();

      for (n = 0; n < ITEMS; n++) begin
         if (n == ITEMS / 2) drain();
         max_gap = (n >= ITEMS / 4 && n < ITEMS / 3) ? 0 : 3;
         case ($urandom_range(0, 9))
            0: d = '0;
            1: d = TOP_BIT | rand64();
            2: d = FIELD_BITS'($urandom_range(1, 255));
            3: d = ALL_ONES - FIELD_BITS'($urandom_range(0, 3));
            default: d = rand64() >> $urandom_range(0, FIELD_BITS - 1);
         endcase
         lo = rand64();
         case ($urandom_range(0, 3))
            0: hi = rand64();
            1: hi = '0;
            2: hi = (d == '0) ? rand64() : rand64() % d;
            default: hi = rand64() >> $urandom_range(0, FIELD_BITS - 1);
         endcase
         send_word(d, lo, hi, max_gap);
      end
      drain();
      repeat (SETTLE) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
